// ===== hdl/plnz_pkg.sv =====
// shared constants, stage-advance vector type and gradient helper for the 2d noise block
// no dependencies; imported by every module of the block but plnz_ram
package plnz_pkg;

    localparam int FRAC_BITS   = 16;
    // table indices wrap by truncation, so the depth stays a power of two
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int PERM_W      = 8;
    localparam int COORD_W     = 24;
    localparam int INT_W       = 8;
    localparam int OUT_W       = FRAC_BITS + 3;
    localparam int OUT_LIMIT   = 2 ** (FRAC_BITS + 1);
    localparam int STAGES      = 9;

    // corner offset and gradient dot product widths
    localparam int XW = FRAC_BITS + 2;
    localparam int GW = FRAC_BITS + 3;

    // one advance enable per pipeline register, stage 1 nearest the input
    typedef logic [STAGES:1] plnz_adv_t;

    // diagonal gradient picked by the low three hash bits
    function automatic logic signed [GW-1:0] grad(
        input logic [2:0]           h,
        input logic signed [XW-1:0] x,
        input logic signed [XW-1:0] y
    );
        logic signed [GW-1:0] xs;
        logic signed [GW-1:0] ys;
        xs = {x[XW-1], x};
        ys = {y[XW-1], y};
        if (h[2] ? h[1] : h[0])
        begin
            xs = -xs;
        end
        if (h[2] ? h[0] : h[1])
        begin
            ys = -ys;
        end
        return xs + ys;
    endfunction

endpackage

// ===== hdl/plnz_ram.sv =====
// generic simple ram: one write port, two read ports, registered read data
// no dependencies
module plnz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== hdl/plnz_fade.sv =====
// quintic fade curve 6t^5 - 15t^4 + 10t^3 as four multiply stages (pipeline stages 2 to 5)
// depends on plnz_pkg
module plnz_fade (
    input  logic                           clk,
    input  plnz_pkg::plnz_adv_t            adv,
    input  logic [plnz_pkg::FRAC_BITS-1:0] t,
    output logic [plnz_pkg::FRAC_BITS:0]   fade
);
    import plnz_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int SW = F + 6;
    localparam int PW = F + 1 + SW;

    localparam logic signed [PW-1:0] HALF    = PW'(1) <<< (F - 1);
    localparam logic signed [SW-1:0] FIFTEEN = SW'(15) <<< F;
    localparam logic signed [SW-1:0] TEN     = SW'(10) <<< F;
    localparam logic signed [SW-1:0] ONE_S   = SW'(1) <<< F;

    logic signed [F:0]    ts1;
    logic signed [SW-1:0] tw;
    logic signed [SW-1:0] s0;
    logic signed [PW-1:0] p1;
    logic signed [PW-1:0] p2;
    logic signed [PW-1:0] p3;
    logic signed [PW-1:0] p4;
    logic signed [SW-1:0] w;
    logic [F:0]           fade_next;

    logic signed [SW-1:0] m1_reg;
    logic signed [SW-1:0] m2_reg;
    logic signed [SW-1:0] m3_reg;
    logic [F-1:0]         t2_reg;
    logic [F-1:0]         t3_reg;
    logic [F-1:0]         t4_reg;
    logic [F:0]           fade_reg;

    always_comb
    begin
        ts1 = $signed({1'b0, t});
        tw  = SW'(ts1);
        s0  = (tw <<< 2) + (tw <<< 1) - FIFTEEN;
        p1  = ts1 * s0;
        p2  = $signed({1'b0, t2_reg}) * m1_reg;
        p3  = $signed({1'b0, t3_reg}) * m2_reg;
        p4  = $signed({1'b0, t4_reg}) * m3_reg;
        w   = SW'((p4 + HALF) >>> F);
        if (w < 0)
        begin
            fade_next = '0;
        end
        else if (w > ONE_S)
        begin
            fade_next = {1'b1, {F{1'b0}}};
        end
        else
        begin
            fade_next = w[F:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            m1_reg <= SW'((p1 + HALF) >>> F) + TEN;
            t2_reg <= t;
        end
        if (adv[3])
        begin
            m2_reg <= SW'((p2 + HALF) >>> F);
            t3_reg <= t2_reg;
        end
        if (adv[4])
        begin
            m3_reg <= SW'((p3 + HALF) >>> F);
            t4_reg <= t3_reg;
        end
        if (adv[5])
        begin
            fade_reg <= fade_next;
        end
    end

    assign fade = fade_reg;

endmodule

// ===== hdl/plnz_blend.sv =====
// corner gradients, the three interpolations and output saturation (pipeline stages 3 to 9)
// depends on plnz_pkg
module plnz_blend (
    input  logic                                  clk,
    input  plnz_pkg::plnz_adv_t                   adv,
    input  logic [2:0]                            h00,
    input  logic [2:0]                            h10,
    input  logic [2:0]                            h01,
    input  logic [2:0]                            h11,
    input  logic [plnz_pkg::FRAC_BITS-1:0]        fx,
    input  logic [plnz_pkg::FRAC_BITS-1:0]        fy,
    input  logic [plnz_pkg::FRAC_BITS:0]          u,
    input  logic [plnz_pkg::FRAC_BITS:0]          v,
    output logic signed [plnz_pkg::OUT_W-1:0]     noise
);
    import plnz_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int DW  = F + 4;
    localparam int LW  = F + 5;
    localparam int EW  = F + 6;
    localparam int RW  = F + 7;
    localparam int PW0 = F + 2 + DW;
    localparam int PW2 = F + 2 + EW;

    localparam logic signed [PW0-1:0] HALF0 = PW0'(1) <<< (F - 1);
    localparam logic signed [PW2-1:0] HALF2 = PW2'(1) <<< (F - 1);
    localparam logic signed [RW-1:0]  LIM_HI = RW'(OUT_LIMIT);
    localparam logic signed [RW-1:0]  LIM_LO = -RW'(OUT_LIMIT);

    logic signed [XW-1:0]  x0;
    logic signed [XW-1:0]  x1;
    logic signed [XW-1:0]  y0;
    logic signed [XW-1:0]  y1;
    logic signed [PW0-1:0] p0;
    logic signed [PW0-1:0] p1;
    logic signed [PW2-1:0] p2;
    logic signed [OUT_W-1:0] noise_next;

    logic signed [GW-1:0] g00_3_reg;
    logic signed [GW-1:0] g10_3_reg;
    logic signed [GW-1:0] g01_3_reg;
    logic signed [GW-1:0] g11_3_reg;
    logic signed [GW-1:0] g00_4_reg;
    logic signed [GW-1:0] g01_4_reg;
    logic signed [DW-1:0] d0_4_reg;
    logic signed [DW-1:0] d1_4_reg;
    logic signed [GW-1:0] g00_5_reg;
    logic signed [GW-1:0] g01_5_reg;
    logic signed [DW-1:0] d0_5_reg;
    logic signed [DW-1:0] d1_5_reg;
    logic signed [LW-1:0] l0_6_reg;
    logic signed [LW-1:0] l1_6_reg;
    logic [F:0]           v_6_reg;
    logic signed [LW-1:0] l0_7_reg;
    logic signed [EW-1:0] dd_7_reg;
    logic [F:0]           v_7_reg;
    logic signed [RW-1:0] r_8_reg;
    logic signed [OUT_W-1:0] noise_reg;

    always_comb
    begin
        // far corner offsets are the fraction minus one
        x0 = $signed({2'b00, fx});
        x1 = $signed({2'b11, fx});
        y0 = $signed({2'b00, fy});
        y1 = $signed({2'b11, fy});
        p0 = $signed({1'b0, u}) * d0_5_reg;
        p1 = $signed({1'b0, u}) * d1_5_reg;
        p2 = $signed({1'b0, v_7_reg}) * dd_7_reg;
        if (r_8_reg > LIM_HI)
        begin
            noise_next = OUT_W'(LIM_HI);
        end
        else if (r_8_reg < LIM_LO)
        begin
            noise_next = OUT_W'(LIM_LO);
        end
        else
        begin
            noise_next = OUT_W'(r_8_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            g00_3_reg <= grad(h00, x0, y0);
            g10_3_reg <= grad(h10, x1, y0);
            g01_3_reg <= grad(h01, x0, y1);
            g11_3_reg <= grad(h11, x1, y1);
        end
        if (adv[4])
        begin
            g00_4_reg <= g00_3_reg;
            g01_4_reg <= g01_3_reg;
            d0_4_reg  <= DW'(g10_3_reg) - DW'(g00_3_reg);
            d1_4_reg  <= DW'(g11_3_reg) - DW'(g01_3_reg);
        end
        if (adv[5])
        begin
            g00_5_reg <= g00_4_reg;
            g01_5_reg <= g01_4_reg;
            d0_5_reg  <= d0_4_reg;
            d1_5_reg  <= d1_4_reg;
        end
        if (adv[6])
        begin
            l0_6_reg <= LW'(g00_5_reg) + LW'((p0 + HALF0) >>> F);
            l1_6_reg <= LW'(g01_5_reg) + LW'((p1 + HALF0) >>> F);
            v_6_reg  <= v;
        end
        if (adv[7])
        begin
            l0_7_reg <= l0_6_reg;
            dd_7_reg <= EW'(l1_6_reg) - EW'(l0_6_reg);
            v_7_reg  <= v_6_reg;
        end
        if (adv[8])
        begin
            r_8_reg <= RW'(l0_7_reg) + RW'((p2 + HALF2) >>> F);
        end
        if (adv[9])
        begin
            noise_reg <= noise_next;
        end
    end

    assign noise = noise_reg;

endmodule

// ===== hdl/perlin_noise_2d.sv =====
// top level of the 2d gradient noise block: valid chain, table copies, hashing
// depends on plnz_pkg, plnz_ram, plnz_fade, plnz_blend
//
//   channel | handshake            | word
//   --------+----------------------+----------------------------------------------
//   in      | in_valid / in_stall  | action, coord_x, coord_y, table_index, table_value
//   out     | out_valid / out_stall| noise_value
//
// one word per cycle in and out while no stall is raised; an evaluate word reaches
// the output register through the nine-stage pipeline (two table lookups, four fade
// multiplies, three interpolation stages and saturation).
// loads write three copies of the table, each at the stage that reads it, and
// leave the pipeline after stage 1. reset clears the valid bits only.
// a stall on the output holds each full stage with no empty stage after it; bubbles still close up.
module perlin_noise_2d (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  action,
    input  logic [plnz_pkg::COORD_W-1:0]          coord_x,
    input  logic [plnz_pkg::COORD_W-1:0]          coord_y,
    input  logic [plnz_pkg::PERM_W-1:0]           table_index,
    input  logic [plnz_pkg::PERM_W-1:0]           table_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [plnz_pkg::OUT_W-1:0]     noise_value
);
    import plnz_pkg::*;

    localparam int HW = PERM_W + 1;

    plnz_adv_t         adv;
    logic [STAGES:1]   valid_reg;
    logic [STAGES:1]   valid_next;
    logic              accept;
    logic              ld_ok_in;
    logic [INT_W-1:0]  xi_in;

    logic              act1_reg;
    logic              ld_ok1_reg;
    logic [INT_W-1:0]  yi1_reg;
    logic [FRAC_BITS-1:0] fx1_reg;
    logic [FRAC_BITS-1:0] fy1_reg;
    logic [ADDR_W-1:0] tidx1_reg;
    logic [PERM_W-1:0] tval1_reg;
    logic [FRAC_BITS-1:0] fx2_reg;
    logic [FRAC_BITS-1:0] fy2_reg;

    logic [PERM_W-1:0] px0;
    logic [PERM_W-1:0] px1;
    logic [HW-1:0]     hash_a;
    logic [HW-1:0]     hash_b;
    logic [PERM_W-1:0] h00;
    logic [PERM_W-1:0] h01;
    logic [PERM_W-1:0] h10;
    logic [PERM_W-1:0] h11;
    logic              we_mid;
    logic [FRAC_BITS:0] fade_u;
    logic [FRAC_BITS:0] fade_v;

    // a stage advances when it is empty or the one after it advances
    always_comb
    begin
        adv[STAGES] = !valid_reg[STAGES] || !out_stall;
        for (int k = STAGES - 1; k >= 1; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k + 1];
        end
    end

    assign in_stall  = !adv[1];
    assign accept    = in_valid && adv[1];
    assign out_valid = valid_reg[STAGES];
    assign ld_ok_in  = 32'(table_index) < TABLE_DEPTH;
    assign xi_in     = coord_x[FRAC_BITS +: INT_W];

    always_comb
    begin
        valid_next = valid_reg;
        if (adv[1])
        begin
            valid_next[1] = in_valid;
        end
        // load words drop out once the last table copy is written
        if (adv[2])
        begin
            valid_next[2] = valid_reg[1] && !act1_reg;
        end
        for (int k = 3; k <= STAGES; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            act1_reg   <= action;
            ld_ok1_reg <= ld_ok_in;
            yi1_reg    <= coord_y[FRAC_BITS +: INT_W];
            fx1_reg    <= coord_x[FRAC_BITS-1:0];
            fy1_reg    <= coord_y[FRAC_BITS-1:0];
            tidx1_reg  <= ADDR_W'(table_index);
            tval1_reg  <= table_value;
        end
        if (adv[2])
        begin
            fx2_reg <= fx1_reg;
            fy2_reg <= fy1_reg;
        end
    end

    // stage 1 copy: perm[xi] and perm[xi + 1]
    plnz_ram #(
        .WIDTH (PERM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_x (
        .clk     (clk),
        .we      (accept && action && ld_ok_in),
        .waddr   (ADDR_W'(table_index)),
        .wdata   (table_value),
        .re      (adv[1]),
        .raddr_a (ADDR_W'(xi_in)),
        .raddr_b (ADDR_W'({1'b0, xi_in} + (INT_W + 1)'(1))),
        .rdata_a (px0),
        .rdata_b (px1)
    );

    assign hash_a = HW'(px0) + HW'(yi1_reg);
    assign hash_b = HW'(px1) + HW'(yi1_reg);
    assign we_mid = adv[2] && valid_reg[1] && act1_reg && ld_ok1_reg;

    // stage 2 copies: perm[a], perm[a + 1] and perm[b], perm[b + 1]
    plnz_ram #(
        .WIDTH (PERM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_a (
        .clk     (clk),
        .we      (we_mid),
        .waddr   (tidx1_reg),
        .wdata   (tval1_reg),
        .re      (adv[2]),
        .raddr_a (ADDR_W'(hash_a)),
        .raddr_b (ADDR_W'(hash_a + HW'(1))),
        .rdata_a (h00),
        .rdata_b (h01)
    );

    plnz_ram #(
        .WIDTH (PERM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_b (
        .clk     (clk),
        .we      (we_mid),
        .waddr   (tidx1_reg),
        .wdata   (tval1_reg),
        .re      (adv[2]),
        .raddr_a (ADDR_W'(hash_b)),
        .raddr_b (ADDR_W'(hash_b + HW'(1))),
        .rdata_a (h10),
        .rdata_b (h11)
    );

    plnz_fade u_fade_x (
        .clk  (clk),
        .adv  (adv),
        .t    (fx1_reg),
        .fade (fade_u)
    );

    plnz_fade u_fade_y (
        .clk  (clk),
        .adv  (adv),
        .t    (fy1_reg),
        .fade (fade_v)
    );

    plnz_blend u_blend (
        .clk   (clk),
        .adv   (adv),
        .h00   (h00[2:0]),
        .h10   (h10[2:0]),
        .h01   (h01[2:0]),
        .h11   (h11[2:0]),
        .fx    (fx2_reg),
        .fy    (fy2_reg),
        .u     (fade_u),
        .v     (fade_v),
        .noise (noise_value)
    );

`ifndef SYNTH
    // any empty stage lets the input through
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg != '1) |-> !in_stall)
        else $error("input stalled with a bubble in the pipeline");

    // a load never occupies stage 2
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv[2] && valid_reg[1] && act1_reg) |=> !valid_reg[2])
        else $error("load word carried past the table stages");

    // an evaluate word leaving stage 8 shows up at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[STAGES - 1] && adv[STAGES]) |=> out_valid)
        else $error("result lost between the last two stages");
`endif

endmodule
